// File: hw/rtl/lrg_pkg.sv
// ----------------------------------------------------------------------------
// lrg_pkg: shared types and constants of the 4 ms grid resampler
// Widths, grid constants, state machine types and the request/response
// structs that connect the resampler to its shared multiply/divide unit.
// ----------------------------------------------------------------------------
package lrg_pkg;

  // Field widths.
  localparam int TIME_W  = 40;
  localparam int VALUE_W = 32;

  // Most grid points that one sample may produce.
  localparam int MAX_GRID_OUT = 64;
  localparam int CNT_W        = $clog2(MAX_GRID_OUT + 1);

  // Grid spacing and look-ahead, in microseconds.
  localparam int GRID_STEP_US = 4000;
  localparam int LOOKAHEAD_US = 100;

  // Grid time is tracked with headroom above the stored 40 bits.
  localparam int GRID_W = TIME_W + 2;

  // Shared multiply/divide unit operand widths.
  localparam int MD_A_W    = GRID_W;            // |grid - previous time|
  localparam int MD_B_W    = VALUE_W + 2;       // |value difference|
  localparam int MD_D_W    = TIME_W;            // |time span|
  localparam int MD_Q_W    = VALUE_W + 2;       // quotient, capped at 2^33
  localparam int MD_P_W    = MD_A_W + MD_B_W;   // product width
  localparam int MD_CNT_W  = $clog2(MD_P_W);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_DELTA_ENCODED       = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIXED_INTERVAL_MODE = 8'd1;

  // Input item kinds.
  localparam logic KIND_SAMPLE  = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_CHECK,
    S_MD,
    S_SKIP,
    S_EMIT
  } lrg_state_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV,
    MD_FIN
  } md_state_t;

  typedef struct packed {
    logic              start;
    logic [MD_A_W-1:0] a;
    logic [MD_B_W-1:0] b;
    logic [MD_D_W-1:0] d;
  } md_req_t;

  typedef struct packed {
    logic              done;
    logic [MD_Q_W-1:0] quot;
    logic [MD_D_W-1:0] rem;
  } md_rsp_t;

endpackage

// File: hw/rtl/lrg_muldiv.sv
// ----------------------------------------------------------------------------
// lrg_muldiv: shared shift-add multiplier and restoring divider
// Computes min(floor(a*b/d), 2^33) and the remainder (a*b) mod d, one bit
// per cycle: a multiply pass over the bits of b, then a divide pass.
// ----------------------------------------------------------------------------
module lrg_muldiv (
  input  logic             clk,
  input  logic             rst_n,
  input  lrg_pkg::md_req_t req,
  output lrg_pkg::md_rsp_t rsp
);

  localparam logic [lrg_pkg::MD_Q_W-1:0] QUOT_CAP = {1'b1, {(lrg_pkg::MD_Q_W-1){1'b0}}};

  lrg_pkg::md_state_t state_r, state_nxt;

  logic [lrg_pkg::MD_CNT_W-1:0] cnt_r;
  logic [lrg_pkg::MD_A_W-1:0]   a_r;
  logic [lrg_pkg::MD_D_W-1:0]   d_r;
  logic [lrg_pkg::MD_P_W-1:0]   prod_r;
  logic [lrg_pkg::MD_D_W-1:0]   rem_r;
  logic [lrg_pkg::MD_Q_W-1:0]   quot_r;

  logic [lrg_pkg::MD_A_W:0]     mul_sum;
  logic [lrg_pkg::MD_D_W:0]     trial;
  logic                         trial_ge;
  logic [lrg_pkg::MD_Q_W-1:0]   quot_shift;
  logic                         last_mul;
  logic                         last_div;

  always_comb begin
    mul_sum = {1'b0, prod_r[lrg_pkg::MD_P_W-1:lrg_pkg::MD_B_W]}
            + (prod_r[0] ? {1'b0, a_r} : '0);
    trial      = {rem_r, prod_r[lrg_pkg::MD_P_W-1]};
    trial_ge   = (trial >= {1'b0, d_r});
    quot_shift = {quot_r[lrg_pkg::MD_Q_W-2:0], trial_ge};
    last_mul   = (cnt_r == lrg_pkg::MD_CNT_W'(lrg_pkg::MD_B_W - 1));
    last_div   = (cnt_r == lrg_pkg::MD_CNT_W'(lrg_pkg::MD_P_W - 1));
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lrg_pkg::MD_IDLE: if (req.start) state_nxt = lrg_pkg::MD_MUL;
      lrg_pkg::MD_MUL:  if (last_mul) state_nxt = lrg_pkg::MD_DIV;
      lrg_pkg::MD_DIV:  if (last_div) state_nxt = lrg_pkg::MD_FIN;
      lrg_pkg::MD_FIN:  state_nxt = lrg_pkg::MD_IDLE;
      default:          state_nxt = lrg_pkg::MD_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    rsp.done = (state_r == lrg_pkg::MD_FIN);
    rsp.quot = quot_r;
    rsp.rem  = rem_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lrg_pkg::MD_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r != state_nxt) begin
        cnt_r <= '0;
      end else begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      lrg_pkg::MD_IDLE: begin
        if (req.start) begin
          a_r    <= req.a;
          d_r    <= req.d;
          prod_r <= {{lrg_pkg::MD_A_W{1'b0}}, req.b};
          rem_r  <= '0;
          quot_r <= '0;
        end
      end
      lrg_pkg::MD_MUL: begin
        prod_r <= {mul_sum, prod_r[lrg_pkg::MD_B_W-1:1]};
      end
      lrg_pkg::MD_DIV: begin
        prod_r <= {prod_r[lrg_pkg::MD_P_W-2:0], 1'b0};
        if (trial_ge) begin
          rem_r <= lrg_pkg::MD_D_W'(trial - {1'b0, d_r});
        end else begin
          rem_r <= trial[lrg_pkg::MD_D_W-1:0];
        end
        // The quotient saturates once it reaches the cap.
        if (quot_r[lrg_pkg::MD_Q_W-1] || quot_shift[lrg_pkg::MD_Q_W-1]) begin
          quot_r <= QUOT_CAP;
        end else begin
          quot_r <= quot_shift;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: hw/rtl/linear_resampler_to_4ms_grid.sv
// ----------------------------------------------------------------------------
// linear_resampler_to_4ms_grid: linear interpolation onto a 4 ms time grid
// Takes timed Q16.16 samples and emits interpolated values at every 4000 us
// grid point, or passes values through in fixed-interval mode.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake            Payload
//   in_      input      in_valid / in_stall  kind, sample_time, sample_value
//   out_     output     out_valid/out_stall  grid_value, last, overrun
//   cfg_     input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A restart transaction or the first timed sample gives no result; a
// fixed-interval sample goes straight to the emit state. A later timed
// sample is set up in a prepare state, then each grid point takes a check
// state, a pass through the shared multiply/divide unit (multiply steps,
// divide steps, finish state) and an emit state; a zero time span goes
// from check straight to emit. One more check closes the sample, and an
// overrun adds one pass through that unit to find the next grid point.
// Reset is synchronous and active low; it clears the control state, both
// configuration registers and the sample history.
// A full result register with a stalled result holds the sequencer in its
// emit cycle; the input side is taken only while the sequencer is idle.
// ----------------------------------------------------------------------------
module linear_resampler_to_4ms_grid (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input samples.
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_kind,
  input  logic [lrg_pkg::TIME_W-1:0]          in_sample_time,
  input  logic signed [lrg_pkg::VALUE_W-1:0]  in_sample_value,
  // Grid results.
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [lrg_pkg::VALUE_W-1:0]  out_grid_value,
  output logic                                out_last,
  output logic                                out_overrun,
  // Configuration writes.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lrg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic                                cfg_data
);

  localparam logic [lrg_pkg::GRID_W-1:0] GRID_STEP = lrg_pkg::GRID_W'(lrg_pkg::GRID_STEP_US);
  localparam logic [lrg_pkg::GRID_W-1:0] LOOKAHEAD = lrg_pkg::GRID_W'(lrg_pkg::LOOKAHEAD_US);
  localparam logic [lrg_pkg::CNT_W-1:0]  CNT_MAX   = lrg_pkg::CNT_W'(lrg_pkg::MAX_GRID_OUT);
  localparam logic [lrg_pkg::CNT_W-1:0]  CNT_LAST  = lrg_pkg::CNT_W'(lrg_pkg::MAX_GRID_OUT - 1);

  lrg_pkg::lrg_state_t state_r, state_nxt;

  // Configuration.
  logic delta_encoded_r;
  logic fixed_interval_mode_r;

  // Sample history.
  logic                                first_seen_r;
  logic [lrg_pkg::TIME_W-1:0]          prev_time_r;
  logic signed [lrg_pkg::VALUE_W-1:0]  prev_value_r;
  logic [lrg_pkg::TIME_W-1:0]          grid_time_r;

  // Current sample being worked on.
  logic [lrg_pkg::TIME_W-1:0]          cur_time_r;
  logic signed [lrg_pkg::VALUE_W-1:0]  cur_value_r;
  logic [lrg_pkg::GRID_W-1:0]          limit_r;
  logic [lrg_pkg::GRID_W-1:0]          grid_r;
  logic [lrg_pkg::CNT_W-1:0]           count_r;
  logic [lrg_pkg::MD_D_W-1:0]          span_abs_r;
  logic [lrg_pkg::VALUE_W:0]           dv_abs_r;
  logic                                base_neg_r;
  logic                                span_zero_r;
  logic                                neg_r;
  logic                                fixed_item_r;
  // Value of the grid point being prepared, moved to the result on emit.
  logic signed [lrg_pkg::VALUE_W-1:0]  point_value_r;

  // Result register.
  logic                                out_valid_r;
  logic signed [lrg_pkg::VALUE_W-1:0]  res_value_r;
  logic                                out_last_r;
  logic                                out_overrun_r;

  lrg_pkg::md_req_t md_req;
  lrg_pkg::md_rsp_t md_rsp;

  logic in_accept;
  logic out_accept;
  logic slot_free;

  // Combinational datapath terms.
  logic [lrg_pkg::TIME_W-1:0]          dec_time;
  logic signed [lrg_pkg::VALUE_W-1:0]  dec_value;
  logic signed [lrg_pkg::VALUE_W-1:0]  fixed_base;
  logic signed [lrg_pkg::VALUE_W-1:0]  fixed_value;
  logic [lrg_pkg::TIME_W:0]            span;
  logic [lrg_pkg::VALUE_W:0]           dv;
  logic [lrg_pkg::GRID_W:0]            off;
  logic [lrg_pkg::MD_A_W-1:0]          off_abs;
  logic                                loop_go;
  logic                                skip_needed;
  logic [lrg_pkg::GRID_W-1:0]          grid_plus;
  logic                                past_limit;
  logic                                emit_last;
  logic                                emit_overrun;
  logic signed [lrg_pkg::VALUE_W+2:0]  interp_sum;
  logic signed [lrg_pkg::VALUE_W-1:0]  interp_sat;
  logic [lrg_pkg::GRID_W:0]            skip_grid;

  lrg_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (md_req),
    .rsp   (md_rsp)
  );

  assign cfg_ready  = 1'b1;
  assign in_stall   = (state_r != lrg_pkg::S_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid_r && !out_stall;
  // The result register can take a new result when empty or being emptied.
  assign slot_free  = !out_valid_r || !out_stall;

  assign out_valid      = out_valid_r;
  assign out_grid_value = res_value_r;
  assign out_last       = out_last_r;
  assign out_overrun    = out_overrun_r;

  always_comb begin
    // Delta decoding wraps at the field widths.
    dec_time  = delta_encoded_r ? (prev_time_r + in_sample_time) : in_sample_time;
    dec_value = delta_encoded_r ? (prev_value_r + in_sample_value) : in_sample_value;

    // Fixed mode accumulates from zero on the first sample.
    fixed_base  = first_seen_r ? prev_value_r : '0;
    fixed_value = delta_encoded_r ? (fixed_base + in_sample_value) : in_sample_value;

    span = {1'b0, cur_time_r} - {1'b0, prev_time_r};
    dv   = {cur_value_r[lrg_pkg::VALUE_W-1], cur_value_r}
         - {prev_value_r[lrg_pkg::VALUE_W-1], prev_value_r};

    off     = {1'b0, grid_r} - {3'b000, prev_time_r};
    off_abs = off[lrg_pkg::GRID_W] ? lrg_pkg::MD_A_W'(-off) : off[lrg_pkg::GRID_W-1:0];

    // A grid point is due inside the look-ahead window, up to 64 per sample.
    loop_go     = (grid_r <= limit_r) && (count_r < CNT_MAX);
    skip_needed = (grid_r <= limit_r);

    grid_plus    = grid_r + GRID_STEP;
    past_limit   = (grid_plus > limit_r);
    emit_last    = fixed_item_r || past_limit || (count_r == CNT_LAST);
    emit_overrun = !fixed_item_r && !past_limit && (count_r == CNT_LAST);

    // previous_value plus or minus the capped quotient, saturated to 32 bits.
    if (neg_r) begin
      interp_sum = {{3{prev_value_r[lrg_pkg::VALUE_W-1]}}, prev_value_r}
                 - $signed({1'b0, md_rsp.quot});
    end else begin
      interp_sum = {{3{prev_value_r[lrg_pkg::VALUE_W-1]}}, prev_value_r}
                 + $signed({1'b0, md_rsp.quot});
    end
    if (!interp_sum[lrg_pkg::VALUE_W+2]
        && (interp_sum[lrg_pkg::VALUE_W+1:lrg_pkg::VALUE_W-1] != 3'b000)) begin
      interp_sat = {1'b0, {(lrg_pkg::VALUE_W-1){1'b1}}};
    end else if (interp_sum[lrg_pkg::VALUE_W+2]
                 && (interp_sum[lrg_pkg::VALUE_W+1:lrg_pkg::VALUE_W-1] != 3'b111)) begin
      interp_sat = {1'b1, {(lrg_pkg::VALUE_W-1){1'b0}}};
    end else begin
      interp_sat = interp_sum[lrg_pkg::VALUE_W-1:0];
    end

    // After an overrun the grid moves to the first point past the limit:
    // limit + step - ((limit - grid) mod step).
    skip_grid = {1'b0, limit_r} + {1'b0, GRID_STEP}
              - {1'b0, lrg_pkg::GRID_W'(md_rsp.rem)};
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lrg_pkg::S_IDLE: begin
        if (in_accept && (in_kind == lrg_pkg::KIND_SAMPLE)) begin
          if (fixed_interval_mode_r) begin
            state_nxt = lrg_pkg::S_EMIT;
          end else if (first_seen_r) begin
            state_nxt = lrg_pkg::S_PREP;
          end
        end
      end
      lrg_pkg::S_PREP: state_nxt = lrg_pkg::S_CHECK;
      lrg_pkg::S_CHECK: begin
        if (loop_go) begin
          state_nxt = span_zero_r ? lrg_pkg::S_EMIT : lrg_pkg::S_MD;
        end else if (skip_needed) begin
          state_nxt = lrg_pkg::S_SKIP;
        end else begin
          state_nxt = lrg_pkg::S_IDLE;
        end
      end
      lrg_pkg::S_MD:   if (md_rsp.done) state_nxt = lrg_pkg::S_EMIT;
      lrg_pkg::S_SKIP: if (md_rsp.done) state_nxt = lrg_pkg::S_IDLE;
      lrg_pkg::S_EMIT: begin
        if (slot_free) begin
          state_nxt = fixed_item_r ? lrg_pkg::S_IDLE : lrg_pkg::S_CHECK;
        end
      end
      default: state_nxt = lrg_pkg::S_IDLE;
    endcase
  end

  // Requests to the shared multiply/divide unit.
  always_comb begin
    md_req.start = (state_r == lrg_pkg::S_CHECK)
                && ((loop_go && !span_zero_r) || (!loop_go && skip_needed));
    if (loop_go) begin
      md_req.a = off_abs;
      md_req.b = lrg_pkg::MD_B_W'(dv_abs_r);
      md_req.d = span_abs_r;
    end else begin
      // Remainder of the distance to the limit by the grid step.
      md_req.a = limit_r - grid_r;
      md_req.b = lrg_pkg::MD_B_W'(1);
      md_req.d = lrg_pkg::MD_D_W'(lrg_pkg::GRID_STEP_US);
    end
  end

  // Control state and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r               <= lrg_pkg::S_IDLE;
      delta_encoded_r       <= 1'b0;
      fixed_interval_mode_r <= 1'b0;
      out_valid_r           <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          lrg_pkg::CFG_DELTA_ENCODED:       delta_encoded_r       <= cfg_data;
          lrg_pkg::CFG_FIXED_INTERVAL_MODE: fixed_interval_mode_r <= cfg_data;
          default: begin
          end
        endcase
      end
      if ((state_r == lrg_pkg::S_EMIT) && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_accept) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Sample history, reset to zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_seen_r <= 1'b0;
      prev_time_r  <= '0;
      prev_value_r <= '0;
      grid_time_r  <= '0;
    end else begin
      unique case (state_r)
        lrg_pkg::S_IDLE: begin
          if (in_accept) begin
            if (in_kind == lrg_pkg::KIND_RESTART) begin
              first_seen_r <= 1'b0;
            end else if (fixed_interval_mode_r) begin
              first_seen_r <= 1'b1;
              if (delta_encoded_r) begin
                prev_value_r <= fixed_value;
              end else if (!first_seen_r) begin
                prev_value_r <= '0;
              end
            end else if (!first_seen_r) begin
              // The first timed sample is absolute and starts the grid.
              first_seen_r <= 1'b1;
              prev_time_r  <= in_sample_time;
              prev_value_r <= in_sample_value;
              grid_time_r  <= in_sample_time;
            end
          end
        end
        lrg_pkg::S_CHECK: begin
          if (!loop_go && !skip_needed) begin
            prev_time_r  <= cur_time_r;
            prev_value_r <= cur_value_r;
            grid_time_r  <= grid_r[lrg_pkg::TIME_W-1:0];
          end
        end
        lrg_pkg::S_SKIP: begin
          if (md_rsp.done) begin
            prev_time_r  <= cur_time_r;
            prev_value_r <= cur_value_r;
            grid_time_r  <= skip_grid[lrg_pkg::TIME_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Working registers of the current transaction and the result payload.
  // The result payload only changes when a new result is loaded on emit.
  always_ff @(posedge clk) begin
    case (state_r)
      lrg_pkg::S_IDLE: begin
        if (in_accept && (in_kind == lrg_pkg::KIND_SAMPLE)) begin
          fixed_item_r  <= fixed_interval_mode_r;
          point_value_r <= fixed_value;
          cur_time_r    <= dec_time;
          cur_value_r   <= dec_value;
          grid_r        <= {2'b00, grid_time_r};
          count_r       <= '0;
        end
      end
      lrg_pkg::S_PREP: begin
        span_zero_r <= (cur_time_r == prev_time_r);
        span_abs_r  <= span[lrg_pkg::TIME_W] ? lrg_pkg::TIME_W'(-span)
                                             : span[lrg_pkg::TIME_W-1:0];
        dv_abs_r    <= dv[lrg_pkg::VALUE_W] ? (-dv) : dv;
        base_neg_r  <= span[lrg_pkg::TIME_W] ^ dv[lrg_pkg::VALUE_W];
        limit_r     <= {2'b00, cur_time_r} + LOOKAHEAD;
      end
      lrg_pkg::S_CHECK: begin
        neg_r <= base_neg_r ^ off[lrg_pkg::GRID_W];
        if (loop_go && span_zero_r) begin
          point_value_r <= prev_value_r;
        end
      end
      lrg_pkg::S_MD: begin
        if (md_rsp.done) begin
          point_value_r <= interp_sat;
        end
      end
      lrg_pkg::S_EMIT: begin
        if (slot_free) begin
          res_value_r   <= point_value_r;
          out_last_r    <= emit_last;
          out_overrun_r <= emit_overrun;
          grid_r        <= grid_plus;
          count_r       <= count_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: hw/rtl/lrg_checker.sv
// ----------------------------------------------------------------------------
// lrg_checker: port-level checks of the 4 ms grid resampler
// Watches the top level's ports and flags sequencing errors.
// ----------------------------------------------------------------------------
module lrg_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [lrg_pkg::VALUE_W-1:0]  out_grid_value,
  input logic                                out_last,
  input logic                                out_overrun
);

  // A stalled result transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_grid_value)
                               && $stable(out_last) && $stable(out_overrun))
    else $error("stalled result changed");

  // Overrun is only reported on the final result of a sample.
  a_overrun_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overrun |-> out_last)
    else $error("overrun without last");

  // While idle the block has no result in the making.
  a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |=> !$rose(out_valid))
    else $error("result appeared while idle");

  // A sample stays in progress until its last result has been issued.
  a_busy_until_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=> in_stall)
    else $error("input taken before last result");

  // An accepted sample cannot produce a result in the very next cycle.
  a_in_valid_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid) || in_stall)
    else $error("result appeared right after accept");

endmodule

bind linear_resampler_to_4ms_grid lrg_checker u_lrg_checker (.*);
